>>> rtl/lsbx_pkg.sv
// ----------------------------------------------------------------------------
// lsbx_pkg: shared types and constants for the left-shift binary XGCD block
// Holds the default data width, the controller state encoding and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lsbx_pkg;

	// Default operand width in bits.
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ORDER,
		ST_NORM,
		ST_STEP,
		ST_FIN
	} lsbx_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the operands and form their magnitudes
		logic order;   // put the larger remainder first
		logic norm;    // register the leading-bit distance
		logic step;    // shifted subtract with reorder
		logic finish;  // form the coefficients into the output register
	} lsbx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic v3_zero;   // smaller remainder is zero, loop is done
		logic out_full;  // output register holds a beat not yet taken
	} lsbx_sts_t;

endpackage

>>> rtl/lsbx_if.sv
// ----------------------------------------------------------------------------
// lsbx_in_if / lsbx_out_if: valid/ready channels of the XGCD block
// The input channel carries the two signed operands; the output channel
// carries the gcd and the two Bezout coefficients.
// ----------------------------------------------------------------------------
interface lsbx_in_if #(
	parameter int unsigned W = lsbx_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] a;
	logic signed [W-1:0] b;

	modport source (output valid, output a, output b, input ready);
	modport sink   (input valid, input a, input b, output ready);
endinterface

interface lsbx_out_if #(
	parameter int unsigned W = lsbx_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic        [W-2:0] gcd_value;
	logic signed [W-1:0] coef_a;
	logic signed [W-1:0] coef_b;

	modport source (output valid, output gcd_value, output coef_a, output coef_b,
		input ready);
	modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
		output ready);
endinterface

>>> rtl/lsbx_ctrl.sv
// ----------------------------------------------------------------------------
// lsbx_ctrl: sequencer of the XGCD block
// Steps one operand pair through ordering, alternating normalize and
// subtract rounds, and the final coefficient correction.
// ----------------------------------------------------------------------------
module lsbx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  lsbx_pkg::lsbx_sts_t sts,
	output lsbx_pkg::lsbx_cmd_t cmd
);

	lsbx_pkg::lsbx_state_t state_q;
	lsbx_pkg::lsbx_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsbx_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			lsbx_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = lsbx_pkg::ST_ORDER;
				end
			end
			lsbx_pkg::ST_ORDER: begin
				cmd.order = 1'b1;
				state_nxt = lsbx_pkg::ST_NORM;
			end
			lsbx_pkg::ST_NORM: begin
				if (sts.v3_zero) begin
					state_nxt = lsbx_pkg::ST_FIN;
				end else begin
					cmd.norm  = 1'b1;
					state_nxt = lsbx_pkg::ST_STEP;
				end
			end
			lsbx_pkg::ST_STEP: begin
				cmd.step  = 1'b1;
				state_nxt = lsbx_pkg::ST_NORM;
			end
			lsbx_pkg::ST_FIN: begin
				// Wait here while the previous result is still unclaimed.
				if (!sts.out_full || out_ready) begin
					cmd.finish = 1'b1;
					state_nxt  = lsbx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lsbx_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/lsbx_dp.sv
// ----------------------------------------------------------------------------
// lsbx_dp: datapath of the XGCD block
// Holds the remainder pair with its cofactors, the leading-bit distance,
// the operand magnitudes and signs, and the output register.
// ----------------------------------------------------------------------------
module lsbx_dp #(
	parameter int unsigned DATA_WIDTH = lsbx_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	input  logic                  out_ready,
	input  lsbx_pkg::lsbx_cmd_t   cmd,
	output lsbx_pkg::lsbx_sts_t   sts,
	output logic                  out_valid,
	output logic [DATA_WIDTH-2:0] gcd_value,
	output logic [DATA_WIDTH-1:0] coef_a,
	output logic [DATA_WIDTH-1:0] coef_b
);

	localparam int unsigned KW = $clog2(DATA_WIDTH);
	localparam logic [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1);
	localparam logic [DATA_WIDTH-1:0] ONES = '1;

	// Operand magnitudes and signs, kept for the final correction.
	logic [DATA_WIDTH-1:0] ma_q, mb_q;
	logic                  na_q, nb_q;
	// Remainders and cofactors: u is the larger, v the smaller.
	logic [DATA_WIDTH-1:0] u1_q, u2_q, u3_q;
	logic [DATA_WIDTH-1:0] v1_q, v2_q, v3_q;
	logic [KW-1:0]         k_q;
	// Output register.
	logic                  out_valid_q;
	logic [DATA_WIDTH-2:0] gcd_q;
	logic [DATA_WIDTH-1:0] coef_a_q, coef_b_q;

	logic [DATA_WIDTH-1:0] ma_in, mb_in;
	logic [KW-1:0]         tb_u, tb_v;
	logic [DATA_WIDTH-1:0] sh_full, sh_sel, u3_new, u1_new, u2_new;
	logic                  under;
	logic [KW-1:0]         k_use;
	logic [DATA_WIDTH-1:0] s_fin, t_fin;

	// Magnitudes of the incoming operands.
	assign ma_in = a[DATA_WIDTH-1] ? (~a + ONE) : a;
	assign mb_in = b[DATA_WIDTH-1] ? (~b + ONE) : b;

	// Leading-bit positions of both remainders.
	always_comb begin
		tb_u = '0;
		tb_v = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (u3_q[i]) begin
				tb_u = KW'(i);
			end
			if (v3_q[i]) begin
				tb_v = KW'(i);
			end
		end
	end

	// Shifted subtract; if the full shift overshoots, one position less is used.
	always_comb begin
		sh_full = v3_q << k_q;
		under   = u3_q < sh_full;
		k_use   = under ? (k_q - KW'(1)) : k_q;
		sh_sel  = under ? (sh_full >> 1) : sh_full;
		u3_new  = u3_q - sh_sel;
		u1_new  = u1_q - (v1_q << k_use);
		u2_new  = u2_q - (v2_q << k_use);
	end

	// Coefficients with the special cases for a gcd equal to an operand.
	always_comb begin
		if (u3_q == ma_q) begin
			s_fin = na_q ? ONES : ONE;
			t_fin = '0;
		end else if (u3_q == mb_q) begin
			s_fin = '0;
			t_fin = nb_q ? ONES : ONE;
		end else begin
			s_fin = na_q ? (~u1_q + ONE) : u1_q;
			t_fin = nb_q ? (~u2_q + ONE) : u2_q;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ma_q <= ma_in;
			mb_q <= mb_in;
			na_q <= a[DATA_WIDTH-1];
			nb_q <= b[DATA_WIDTH-1];
			u1_q <= ONE;
			u2_q <= '0;
			u3_q <= ma_in;
			v1_q <= '0;
			v2_q <= ONE;
			v3_q <= mb_in;
		end else if (cmd.order) begin
			if (u3_q < v3_q) begin
				u1_q <= v1_q;
				u2_q <= v2_q;
				u3_q <= v3_q;
				v1_q <= u1_q;
				v2_q <= u2_q;
				v3_q <= u3_q;
			end
		end else if (cmd.norm) begin
			k_q <= tb_u - tb_v;
		end else if (cmd.step) begin
			if (u3_new < v3_q) begin
				u1_q <= v1_q;
				u2_q <= v2_q;
				u3_q <= v3_q;
				v1_q <= u1_new;
				v2_q <= u2_new;
				v3_q <= u3_new;
			end else begin
				u1_q <= u1_new;
				u2_q <= u2_new;
				u3_q <= u3_new;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			gcd_q    <= u3_q[DATA_WIDTH-2:0];
			coef_a_q <= s_fin;
			coef_b_q <= t_fin;
		end
	end

	// Output valid: set on finish, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.v3_zero  = (v3_q == '0);
	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign gcd_value    = gcd_q;
	assign coef_a       = coef_a_q;
	assign coef_b       = coef_b_q;

endmodule

>>> rtl/left_shift_binary_xgcd.sv
// ----------------------------------------------------------------------------
// left_shift_binary_xgcd: extended GCD by left-shift binary reduction
// Returns gcd(|a|,|b|) with Bezout coefficients coef_a, coef_b such that
// gcd = coef_a*a + coef_b*b.
// ----------------------------------------------------------------------------
// Usage:
// The operand pair a, b arrives as one beat on in_ch; the result (gcd_value,
// coef_a, coef_b) leaves as one beat on out_ch. Both are valid/ready channels.
// One pair is worked on at a time; in_ch.ready is high only while the block
// is idle. After an accepted beat the block orders the pair, then runs
// reduction rounds (leading-bit distance, then the shifted subtract), then
// tests for the end and corrects the coefficients. Each round drops at
// least one bit from the remainder pair, so the number of rounds is at
// most 2*DATA_WIDTH-3 (61 rounds for 32 bits).
// The result sits in an output register, so a new pair is accepted while
// the previous result waits. If the receiver still holds off when the next
// result is ready, the block waits and takes no input until out_ch frees up.
// Reset clears the controller to idle and drops out_ch.valid.
// ----------------------------------------------------------------------------
module left_shift_binary_xgcd #(
	parameter int unsigned DATA_WIDTH = lsbx_pkg::DATA_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lsbx_in_if.sink     in_ch,
	lsbx_out_if.source  out_ch
);

	lsbx_pkg::lsbx_cmd_t   cmd;
	lsbx_pkg::lsbx_sts_t   sts;
	logic [DATA_WIDTH-1:0] coef_a_w, coef_b_w;

	// Sequencer.
	lsbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and output register.
	lsbx_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.a         (in_ch.a),
		.b         (in_ch.b),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.gcd_value (out_ch.gcd_value),
		.coef_a    (coef_a_w),
		.coef_b    (coef_b_w)
	);

	assign out_ch.coef_a = coef_a_w;
	assign out_ch.coef_b = coef_b_w;

	// Only one datapath command is issued in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.order, cmd.norm, cmd.step, cmd.finish}))
		else $error("more than one datapath command at once");

	// After an input beat the block is busy and takes no second pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted while a pair is in work");

	// A finished result always shows up on the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_ch.valid)
		else $error("finished result not presented");

	// A result is never loaded over one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_ch.valid || out_ch.ready))
		else $error("output beat overwritten");

endmodule
